### src/npsx_pkg.sv
// ----------------------------------------------------------------------------
// npsx_pkg
// Types and constants shared by the nearest point search core.
// ----------------------------------------------------------------------------
package npsx_pkg;

   localparam int MAX_POINTS_DEF = 1024;
   localparam int COORD_BITS_DEF = 24;
   localparam int ID_BITS        = 10;
   localparam int DIST_BITS      = 52;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_FOUND = 2'd2,
      ST_NONE  = 2'd3
   } status_type;

   localparam logic [2:0] QUAD_PXPY = 3'd0;
   localparam logic [2:0] QUAD_PXNY = 3'd1;
   localparam logic [2:0] QUAD_NXNY = 3'd2;
   localparam logic [2:0] QUAD_NXPY = 3'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_BS_EDGE,
      S_BS_RD,
      S_BS_CHK,
      S_PICK_RD,
      S_PICK,
      S_SCAN_RD,
      S_SCAN,
      S_OUT
   } state_type;

   // ysel: 0 any, 1 dy >= 0 only, 2 dy <= 0 only
   localparam logic [1:0] YSEL_ANY = 2'd0;
   localparam logic [1:0] YSEL_POS = 2'd1;
   localparam logic [1:0] YSEL_NEG = 2'd2;

endpackage

### src/nearest_point_search_sorted_x_core.sv
// ----------------------------------------------------------------------------
// nearest_point_search_sorted_x_core
// Nearest point search over a point store kept sorted by x.
// ----------------------------------------------------------------------------
// One item at a time. A clear, an undefined command, a query on fewer than
// two points and a load into an empty or full store go straight to the
// output state. Any other load walks the store from the top over the stored
// points with larger x, moving each entry up one slot (memory read then
// write). A query runs a binary search, one halving per step, then scans
// the points one by one through the single memory read port, each point
// read and then checked. It may end the scan or turn it to the other side,
// then forms the result. The scan length depends on the data. Results wait
// in an output register. The next item is accepted while a result still
// waits, and the core holds in its output state only while the previous
// result has not been taken.
module nearest_point_search_sorted_x_core import npsx_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command[1:0], coord_x[25:2], coord_y[49:26], quadrant[52:50], zero fill
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], point_id[11:2], dist_sq[63:12]
   output logic [63:0] rsp_tdata
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int EW = 2 * COORD_BITS + ID_BITS;
   localparam int DW = COORD_BITS + 1;
   localparam int SW = 2 * DW;
   localparam logic signed [CW:0] IDX_ONE = (CW+1)'(1);

   // request fields
   cmd_type                 req_cmd;
   logic signed [23:0]      req_x24, req_y24;
   logic [2:0]              req_quad;
   assign req_cmd  = cmd_type'(req_tdata[1:0]);
   assign req_x24  = req_tdata[25:2];
   assign req_y24  = req_tdata[49:26];
   assign req_quad = req_tdata[52:50];

   state_type state_ff, state_in;

   logic [CW-1:0]             count_ff, count_in;
   logic signed [COORD_BITS-1:0] qx_ff, qx_in, qy_ff, qy_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [2:0]                quad_ff, quad_in;
   logic signed [CW:0]        lo_ff, lo_in, hi_ff, hi_in, idx_ff, idx_in;
   logic signed [CW:0]        ax_ff, ax_in;
   logic                      dir_ff, dir_in;     // 1 downward
   logic                      second_ff, second_in;
   logic [1:0]                ysel_ff, ysel_in;
   logic                      found_ff, found_in;
   logic [ID_BITS-1:0]        bid_ff, bid_in;
   logic [SW:0]               bd_ff, bd_in;
   logic signed [COORD_BITS-1:0] lox_ff, lox_in;
   logic [1:0]                st_ff, st_in;
   logic                      rv_ff, rv_in;
   logic [63:0]               rd_ff, rd_in;

   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [EW-1:0] rd_data, wr_data;

   npsx_store #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_store (
      .clock(clock), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
   );

   logic signed [COORD_BITS-1:0] m_x, m_y;
   logic [ID_BITS-1:0]           m_id;
   assign m_x  = rd_data[COORD_BITS-1:0];
   assign m_y  = rd_data[2*COORD_BITS-1:COORD_BITS];
   assign m_id = rd_data[EW-1:2*COORD_BITS];

   // distance terms of the entry just read
   logic signed [DW-1:0] dx, dy;
   logic [DW-1:0]        adx, ady;
   logic [SW-1:0]        sx, sy;
   logic [SW:0]          dsum;
   assign dx   = DW'(m_x) - DW'(qx_ff);
   assign dy   = DW'(m_y) - DW'(qy_ff);
   assign adx  = dx[DW-1] ? DW'(-dx) : DW'(dx);
   assign ady  = dy[DW-1] ? DW'(-dy) : DW'(dy);
   assign sx   = SW'(adx) * SW'(adx);
   assign sy   = SW'(ady) * SW'(ady);
   assign dsum = (SW+1)'(sx) + (SW+1)'(sy);

   logic signed [CW:0] cnt_s, mid;
   assign cnt_s = (CW+1)'(count_ff);
   assign mid   = lo_ff + ((hi_ff - lo_ff) >>> 1);

   logic idx_ok;
   assign idx_ok = (idx_ff >= 0) && (idx_ff < cnt_s);

   // entry read lies above the new point and must move up; below slot 0 the
   // walk is over and the new point goes to slot 0
   logic shift_more;
   assign shift_more = !idx_ff[CW] && (m_x > qx_ff);

   logic out_free;
   assign out_free = !rv_ff || rsp_tready;

   logic accept;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      qx_ff <= qx_in; qy_ff <= qy_in; cmd_ff <= cmd_in; quad_ff <= quad_in;
      lo_ff <= lo_in; hi_ff <= hi_in; idx_ff <= idx_in; ax_ff <= ax_in;
      dir_ff <= dir_in; second_ff <= second_in; ysel_ff <= ysel_in;
      found_ff <= found_in; bid_ff <= bid_in; bd_ff <= bd_in;
      lox_ff <= lox_in; st_ff <= st_in; rd_ff <= rd_in;
   end

   // scan helper value
   logic scan_keep;
   always_comb begin
      scan_keep = 1'b1;
      if (ysel_ff == YSEL_POS && dy[DW-1]) scan_keep = 1'b0;
      if (ysel_ff == YSEL_NEG && !dy[DW-1] && dy != '0) scan_keep = 1'b0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_LOAD && count_ff < CW'(MAX_POINTS) && count_ff != '0)
                  state_in = S_SHIFT_RD;
               else if (req_cmd == CMD_QUERY && count_ff >= CW'(2))
                  state_in = S_BS_EDGE;
               else
                  state_in = S_OUT;
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: state_in = shift_more ? S_SHIFT_RD : S_OUT;
         S_BS_EDGE:  state_in = S_BS_RD;
         S_BS_RD:    state_in = S_BS_CHK;
         S_BS_CHK:   state_in = (hi_ff - lo_ff > 1) ? S_BS_CHK : S_PICK_RD;
         S_PICK_RD:  state_in = S_PICK;
         S_PICK:     state_in = S_SCAN_RD;
         S_SCAN_RD:  state_in = idx_ok ? S_SCAN : (second_ff ? S_SCAN_RD : S_OUT);
         S_SCAN: begin
            if (scan_keep && found_ff && (SW+1)'(sx) > bd_ff)
               state_in = second_ff ? S_SCAN_RD : S_OUT;
            else
               state_in = S_SCAN_RD;
         end
         S_OUT:      state_in = out_free ? S_IDLE : S_OUT;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in = count_ff; qx_in = qx_ff; qy_in = qy_ff; cmd_in = cmd_ff;
      quad_in = quad_ff; lo_in = lo_ff; hi_in = hi_ff; idx_in = idx_ff;
      ax_in = ax_ff; dir_in = dir_ff; second_in = second_ff; ysel_in = ysel_ff;
      found_in = found_ff; bid_in = bid_ff; bd_in = bd_ff; lox_in = lox_ff;
      st_in = st_ff; rv_in = rv_ff; rd_in = rd_ff;
      rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0;
      wr_data = {ID_BITS'(count_ff), qy_ff, qx_ff};
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               qx_in = COORD_BITS'(req_x24);
               qy_in = COORD_BITS'(req_y24);
               cmd_in = req_cmd; quad_in = req_quad;
               found_in = 1'b0; bid_in = '0; bd_in = '0;
               st_in = ST_NONE;
               idx_in = cnt_s - IDX_ONE;
               lo_in = '0; hi_in = cnt_s - IDX_ONE;
               unique case (req_cmd)
                  CMD_LOAD: begin
                     if (count_ff >= CW'(MAX_POINTS)) st_in = ST_FULL;
                     else begin
                        st_in = ST_DONE;
                        if (count_ff == '0) begin
                           wr_en = 1'b1; wr_addr = '0;
                           wr_data = {ID_BITS'(0), COORD_BITS'(req_y24),
                                      COORD_BITS'(req_x24)};
                           count_in = CW'(1);
                        end
                     end
                  end
                  CMD_CLEAR: begin count_in = '0; st_in = ST_DONE; end
                  CMD_QUERY, CMD_NONE: ;
                  default: ;
               endcase
               rd_en = 1'b1; rd_addr = AW'(cnt_s - 1);
            end
         end
         S_SHIFT_RD: begin
            rd_en = 1'b1; rd_addr = AW'(idx_ff);
         end
         S_SHIFT_WR: begin
            wr_en = 1'b1;
            wr_addr = AW'(idx_ff + 1);
            if (shift_more) begin
               wr_data = rd_data;
               idx_in = idx_ff - IDX_ONE;
            end else begin
               wr_data = {ID_BITS'(count_ff), qy_ff, qx_ff};
               count_in = count_ff + 1'b1;
            end
         end
         S_BS_EDGE: begin
            // last entry x captured; now read entry 0
            lox_in = m_x; // holds x of top entry
            rd_en = 1'b1; rd_addr = '0;
         end
         S_BS_RD: begin
            if (m_x > qx_ff) begin
               ax_in = '0; lo_in = '0; hi_in = '0;
            end else if (lox_ff < qx_ff) begin
               ax_in = cnt_s - IDX_ONE; lo_in = cnt_s - IDX_ONE;
               hi_in = cnt_s - IDX_ONE;
            end
            lox_in = m_x;
            rd_en = 1'b1; rd_addr = AW'(mid);
         end
         S_BS_CHK: begin
            if (hi_ff - lo_ff > 1) begin
               if (m_x <= qx_ff) begin
                  lo_in = mid; lox_in = m_x;
               end else hi_in = mid;
               rd_en = 1'b1;
               rd_addr = (m_x <= qx_ff) ? AW'(mid + ((hi_ff - mid) >>> 1))
                                        : AW'(lo_ff + ((mid - lo_ff) >>> 1));
            end else begin
               rd_en = 1'b1; rd_addr = AW'(hi_ff);
            end
         end
         S_PICK_RD: begin
            // m_x is x at hi; lox_ff x at lo
            if (hi_ff != lo_ff) begin
               ax_in = ((DW)'(qx_ff) - DW'(lox_ff) < DW'(m_x) - DW'(qx_ff))
                       ? lo_ff : hi_ff;
            end
            rd_en = 1'b1;
            rd_addr = (hi_ff != lo_ff &&
                       ((DW)'(qx_ff) - DW'(lox_ff) < DW'(m_x) - DW'(qx_ff)))
                      ? AW'(lo_ff) : AW'(hi_ff);
         end
         S_PICK: begin
            second_in = 1'b0;
            if (quad_ff == QUAD_PXPY || quad_ff == QUAD_PXNY) begin
               dir_in = 1'b0;
               idx_in = (m_x < qx_ff) ? ax_ff + IDX_ONE : ax_ff;
               ysel_in = (quad_ff == QUAD_PXPY) ? YSEL_POS : YSEL_NEG;
            end else if (quad_ff == QUAD_NXNY || quad_ff == QUAD_NXPY) begin
               dir_in = 1'b1;
               idx_in = (m_x > qx_ff) ? ax_ff - IDX_ONE : ax_ff;
               ysel_in = (quad_ff == QUAD_NXNY) ? YSEL_NEG : YSEL_POS;
            end else begin
               dir_in = 1'b0; idx_in = ax_ff; ysel_in = YSEL_ANY;
               second_in = 1'b1;
            end
         end
         S_SCAN_RD: begin
            if (idx_ok) begin
               rd_en = 1'b1; rd_addr = AW'(idx_ff);
            end else if (second_ff) begin
               second_in = 1'b0; dir_in = 1'b1; idx_in = ax_ff - IDX_ONE;
            end
         end
         S_SCAN: begin
            idx_in = dir_ff ? idx_ff - IDX_ONE : idx_ff + IDX_ONE;
            if (scan_keep) begin
               if (found_ff && (SW+1)'(sx) > bd_ff) begin
                  if (second_ff) begin
                     second_in = 1'b0; dir_in = 1'b1; idx_in = ax_ff - IDX_ONE;
                  end
               end else if (!found_ff || dsum < bd_ff) begin
                  found_in = 1'b1; bd_in = dsum; bid_in = m_id;
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               rv_in = 1'b1;
               if (cmd_ff == CMD_QUERY && found_ff) begin
                  rd_in = {DIST_BITS'(bd_ff), bid_ff, ST_FOUND};
               end else begin
                  rd_in = {DIST_BITS'(0), ID_BITS'(0), st_ff};
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS)) else $error("point count over capacity");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready) else $error("ready while busy");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd == CMD_CLEAR |=> count_ff == '0)
      else $error("clear failed");

endmodule

### src/npsx_store.sv
// ----------------------------------------------------------------------------
// npsx_store
// Point store: one synchronous memory of x, y and id, one read port with a
// registered output and one write port.
// ----------------------------------------------------------------------------
module npsx_store import npsx_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF,
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
   localparam int EW = 2 * COORD_BITS + ID_BITS
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [EW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [EW-1:0] wr_data
);

   logic [EW-1:0] mem [MAX_POINTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the nearest point search core. Loads, clears and
// quadrant queries are streamed in under random idling and stalls, and each
// answer is checked against a local model of the x-sorted point store.
// ----------------------------------------------------------------------------
module tb;
   import npsx_pkg::*;

   localparam int STORE_DEPTH = MAX_POINTS_DEF;
   localparam int WATCHDOG    = 40000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      cmd_type           cmd;
      logic signed [23:0] x;
      logic signed [23:0] y;
      logic [2:0]        quad;
   } point_cmd_type;

   typedef struct {
      status_type  st;
      logic [9:0]  id;
      logic [51:0] dist_sq;
   } answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   nearest_point_search_sorted_x_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #1 clock = ~clock;

   point_cmd_type pending_cmds[$];
   point_cmd_type cur_cmd;
   answer_type    expected_answers[$];

   // model of the store
   longint     store_x[STORE_DEPTH];
   longint     store_y[STORE_DEPTH];
   logic [9:0] store_id[STORE_DEPTH];
   int         store_count = 0;
   bit         best_found;
   logic [9:0] best_id;
   longint     best_dist;

   int  n_sent = 0;
   int  n_answered = 0;
   int  hold_left = 0;
   bit  hold_done = 0;
   bit  req_acc = 0;
   int  quiet_cycles = 0;
   bit  failed = 0;

   function automatic longint sq(longint d);
      return d * d;
   endfunction

   function automatic void scan_store(int start, int dir, logic [1:0] ysel,
                                      longint qx, longint qy);
      longint dx, dy, d;
      for (int i = start; i >= 0 && i < store_count; i += dir) begin
         dx = store_x[i] - qx;
         dy = store_y[i] - qy;
         if (ysel == YSEL_POS && dy < 0) continue;
         if (ysel == YSEL_NEG && dy > 0) continue;
         if (best_found && sq(dx) > best_dist) break;
         d = sq(dx) + sq(dy);
         if (!best_found || d < best_dist) begin
            best_found = 1;
            best_dist  = d;
            best_id    = store_id[i];
         end
      end
   endfunction

   function automatic int nearest_in_x(longint qx);
      int lo, hi, mid;
      lo = 0;
      hi = store_count - 1;
      if (store_x[0] > qx) return 0;
      if (store_x[hi] < qx) return hi;
      while (hi - lo > 1) begin
         mid = lo + (hi - lo) / 2;
         if (store_x[mid] <= qx) lo = mid;
         else hi = mid;
      end
      return (qx - store_x[lo] < store_x[hi] - qx) ? lo : hi;
   endfunction

   function automatic answer_type apply_cmd(point_cmd_type c);
      answer_type a;
      longint  qx, qy;
      int      pos, ax;
      qx = c.x;
      qy = c.y;
      a.st = ST_NONE;
      a.id = '0;
      a.dist_sq = '0;
      case (c.cmd)
         CMD_LOAD: begin
            if (store_count >= STORE_DEPTH) begin
               a.st = ST_FULL;
            end else begin
               pos = store_count;
               while (pos > 0 && store_x[pos-1] > qx) begin
                  store_x[pos]  = store_x[pos-1];
                  store_y[pos]  = store_y[pos-1];
                  store_id[pos] = store_id[pos-1];
                  pos--;
               end
               store_x[pos]  = qx;
               store_y[pos]  = qy;
               store_id[pos] = store_count[9:0];
               store_count++;
               a.st = ST_DONE;
            end
         end
         CMD_CLEAR: begin
            store_count = 0;
            a.st = ST_DONE;
         end
         CMD_QUERY: begin
            if (store_count >= 2) begin
               best_found = 0;
               best_id    = '0;
               best_dist  = 0;
               ax = nearest_in_x(qx);
               if (c.quad == QUAD_PXPY || c.quad == QUAD_PXNY) begin
                  if (store_x[ax] < qx) ax++;
                  scan_store(ax, 1, c.quad == QUAD_PXPY ? YSEL_POS : YSEL_NEG, qx, qy);
               end else if (c.quad == QUAD_NXNY || c.quad == QUAD_NXPY) begin
                  if (store_x[ax] > qx) ax--;
                  scan_store(ax, -1, c.quad == QUAD_NXNY ? YSEL_NEG : YSEL_POS, qx, qy);
               end else begin
                  scan_store(ax, 1, YSEL_ANY, qx, qy);
                  scan_store(ax - 1, -1, YSEL_ANY, qx, qy);
               end
               if (best_found) begin
                  a.st = ST_FOUND;
                  a.id = best_id;
                  a.dist_sq = best_dist[51:0];
               end
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   // idling pattern changes every 150 items
   function automatic bit sender_idles();
      int ph;
      ph = (n_sent / 150) % 4;
      if (ph == 1) return $urandom_range(99) < 61;
      if (ph == 3) return $urandom_range(99) < 37;
      return 0;
   endfunction

   function automatic bit receiver_stalls();
      int ph;
      ph = (n_answered / 150) % 4;
      if (ph == 2) return $urandom_range(99) < 61;
      if (ph == 3) return $urandom_range(99) < 37;
      return 0;
   endfunction

   // driver
   always @(negedge clock) begin
      logic        v;
      logic [55:0] d;
      v = req_tvalid;
      d = req_tdata;
      if (!reset && (!req_tvalid || req_acc)) begin
         v = 1'b0;
         if (pending_cmds.size() > 0 && !sender_idles()) begin
            cur_cmd = pending_cmds.pop_front();
            d = {3'b000, cur_cmd.quad, cur_cmd.y, cur_cmd.x, cur_cmd.cmd};
            v = 1'b1;
         end
      end
      req_tvalid <= v;
      req_tdata  <= d;
   end

   // receiver readiness, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && n_answered == 300) begin
         hold_done  <= 1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !receiver_stalls();
      end
   end

   // item accept, answer check, watchdog
   always @(posedge clock) begin
      point_cmd_type c;
      answer_type    e;
      req_acc <= req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            c.cmd  = cmd_type'(req_tdata[1:0]);
            c.x    = req_tdata[25:2];
            c.y    = req_tdata[49:26];
            c.quad = req_tdata[52:50];
            expected_answers.push_back(apply_cmd(c));
            n_sent <= n_sent + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            n_answered <= n_answered + 1;
            if (expected_answers.size() == 0) begin
               $display("%0t: unexpected item, actual %h", $time, rsp_tdata);
               failed = 1;
            end else begin
               e = expected_answers.pop_front();
               if (rsp_tdata[1:0] !== e.st) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.st,
                           rsp_tdata[1:0]);
                  failed = 1;
               end
               if (rsp_tdata[11:2] !== e.id) begin
                  $display("%0t: point_id expected %0d actual %0d", $time, e.id,
                           rsp_tdata[11:2]);
                  failed = 1;
               end
               if (rsp_tdata[63:12] !== e.dist_sq) begin
                  $display("%0t: dist_sq expected %0d actual %0d", $time, e.dist_sq,
                           rsp_tdata[63:12]);
                  failed = 1;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG) begin
            $display("nearest_point_search_sorted_x_core verification failed");
            $finish;
         end
      end
   end

   task automatic add_cmd(cmd_type cmd, int x, int y, int quad);
      point_cmd_type c;
      c.cmd  = cmd;
      c.x    = x[23:0];
      c.y    = y[23:0];
      c.quad = quad[2:0];
      pending_cmds.push_back(c);
   endtask

   function automatic int rand_coord(bit near);
      if (near) return $urandom_range(64) - 32;
      return int'($urandom) >>> 8;
   endfunction

   initial begin
      int r, since_clear;
      bit near;
      // directed
      add_cmd(CMD_QUERY, 0, 0, 4);
      add_cmd(CMD_LOAD, 0, 0, 0);
      add_cmd(CMD_QUERY, 0, 0, 4);
      add_cmd(CMD_LOAD, -8388608, 8388607, 0);
      add_cmd(CMD_LOAD, 8388607, -8388608, 0);
      add_cmd(CMD_LOAD, 8388607, 8388607, 0);
      add_cmd(CMD_LOAD, -8388608, -8388608, 0);
      add_cmd(CMD_LOAD, 0, 5, 0);
      add_cmd(CMD_LOAD, 0, -5, 0);
      for (int q = 0; q < 8; q++) add_cmd(CMD_QUERY, 1, 1, q);
      add_cmd(CMD_QUERY, -8388608, -8388608, 1);
      add_cmd(CMD_QUERY, 8388607, 8388607, 2);
      add_cmd(CMD_QUERY, 8388607, -8388608, 3);
      add_cmd(CMD_NONE, 8388607, -1, 7);
      add_cmd(CMD_CLEAR, 0, 0, 0);
      add_cmd(CMD_QUERY, 0, 0, 4);
      // fill the store in ascending x, then overflow it
      for (int i = 0; i < STORE_DEPTH; i++)
         add_cmd(CMD_LOAD, i * 8000 - 4000000, rand_coord(0), 0);
      add_cmd(CMD_LOAD, 3, 3, 0);
      add_cmd(CMD_QUERY, rand_coord(0), rand_coord(0), 4);
      add_cmd(CMD_QUERY, rand_coord(0), rand_coord(0), 2);
      add_cmd(CMD_CLEAR, 0, 0, 0);
      // random: small stores, mostly loads and queries
      since_clear = 0;
      for (int i = 0; i < 750; i++) begin
         r = $urandom_range(99);
         near = $urandom_range(1);
         if (since_clear > 60 || r < 2) begin
            add_cmd(CMD_CLEAR, rand_coord(0), rand_coord(0), $urandom_range(7));
            since_clear = 0;
         end else if (r < 3) begin
            add_cmd(CMD_NONE, rand_coord(0), rand_coord(0), $urandom_range(7));
         end else if (r < 55) begin
            add_cmd(CMD_LOAD, rand_coord(near), rand_coord(near), $urandom_range(7));
            since_clear++;
         end else begin
            add_cmd(CMD_QUERY, rand_coord(near), rand_coord(near), $urandom_range(7));
         end
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (pending_cmds.size() > 0 || req_tvalid || expected_answers.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (!failed && expected_answers.size() == 0)
         $display("nearest_point_search_sorted_x_core verification clean");
      else
         $display("nearest_point_search_sorted_x_core verification failed");
      $finish;
   end

endmodule
